[rtl/ndsch_pkg.sv]
// Shared types and constants of the night dimming scheduler.
package ndsch_pkg;

    // Fixed timing constants.
    localparam logic [31:0] DAY_SECONDS    = 32'd86400;
    localparam logic [31:0] HOLD_UPDATE_MS = 32'd1000;
    localparam logic [31:0] FADE_UPDATE_MS = 32'd100;

    // Configuration register indexes.
    localparam int          CFG_INDEX_W          = 8;
    localparam logic [7:0]  REG_NIGHT_ENABLE     = 8'd0;
    localparam logic [7:0]  REG_NIGHT_START      = 8'd1;
    localparam logic [7:0]  REG_NIGHT_END        = 8'd2;
    localparam logic [7:0]  REG_FADE_SECONDS     = 8'd3;
    localparam logic [7:0]  REG_DAY_BRIGHTNESS   = 8'd4;
    localparam logic [7:0]  REG_NIGHT_BRIGHTNESS = 8'd5;
    localparam logic [7:0]  REG_DAY_ECO          = 8'd6;
    localparam logic [7:0]  REG_NIGHT_ECO        = 8'd7;

    // One time tick.
    typedef struct packed {
        logic [31:0] now_seconds;
        logic [31:0] day_start_seconds;
        logic [31:0] ms_time;
        logic        time_valid;
    } tick_t;

    // One result item.
    typedef struct packed {
        logic       night_active;
        logic [7:0] brightness_level;
        logic [7:0] eco_level;
        logic [8:0] fade_level;
    } result_t;

    // One configuration write.
    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
    } cfg_t;

endpackage

[rtl/ndsch_chan_if.sv]
// Valid/ready channel interface used for ticks, results and configuration.
interface ndsch_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/ndsch_ramp_div.sv]
// Serial restoring divider for the fade ramp: level = min(elapsed * full / divisor, full).
module ndsch_ramp_div #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          elapsed,
    input  logic [16:0]          divisor,
    output logic                 busy,
    output logic                 done,
    output logic [FRAC_BITS:0]   level
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t             state_reg;
    logic [16:0]            rem_reg;
    logic [16:0]            div_reg;
    logic [FRAC_BITS-1:0]   quo_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   done_reg;
    logic [FRAC_BITS:0]     level_reg;

    logic [17:0]            rem_dbl;
    logic                   ge;
    logic [17:0]            rem_sub;
    logic [FRAC_BITS-1:0]   quo_new;

    // One quotient bit per cycle: shift the remainder and try a subtract.
    always_comb
    begin
        rem_dbl = {rem_reg, 1'b0};
        ge      = rem_dbl >= {1'b0, div_reg};
        rem_sub = rem_dbl - {1'b0, div_reg};
        quo_new = {quo_reg[FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            level_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        if (divisor == 17'd0)
                        begin
                            // A zero ramp length gives level zero.
                            level_reg <= '0;
                            done_reg  <= 1'b1;
                        end
                        else if ({15'd0, divisor} <= elapsed)
                        begin
                            // The quotient reaches full, so it is capped there.
                            level_reg <= {1'b1, {FRAC_BITS{1'b0}}};
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            rem_reg   <= elapsed[16:0];
                            div_reg   <= divisor;
                            quo_reg   <= '0;
                            cnt_reg   <= CW'(FRAC_BITS);
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? rem_sub[16:0] : rem_dbl[16:0];
                    quo_reg <= quo_new;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        level_reg <= {1'b0, quo_new};
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign busy  = (state_reg == D_RUN);
    assign done  = done_reg;
    assign level = level_reg;

endmodule

[rtl/ndsch_addsub.sv]
// Shared 32-bit adder/subtractor used for all window and elapsed-time sums.
module ndsch_addsub (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        sub,
    output logic [31:0] sum
);

    // Subtract as a plus the two's complement of b; everything wraps modulo 2^32.
    always_comb
    begin
        sum = a + (sub ? ~b : b) + {31'd0, sub};
    end

endmodule

[rtl/night_dimming_scheduler.sv]
// Top level of the night dimming scheduler: configuration, sequencer and result register.
//
// Usage. Ticks arrive on the tick channel (valid/ready); each accepted tick
// produces exactly one result transfer on the result channel. Configuration
// writes arrive on the cfg channel, which is always ready; a write to an
// index beyond the register list is ignored. Configuration is expected to be
// written only while no tick is in flight.
// Each tick is worked through by a small sequencer around one shared 32-bit
// adder, one 9 x (FADE_FRACTION_BITS + 2) bit multiplier and a serial ramp
// divider that yields one quotient bit per cycle. When scheduling is
// disabled or no time is given, the sequencer skips the window and fade
// steps; otherwise it may recompute the window and run a ramp division
// before the blend. tick.ready is low from the transfer until the result is
// loaded, so a new tick is taken only after the previous result is loaded.
// The result register decouples the sides: a finished result waits there
// while the next tick is accepted, and the sequencer only stalls at its last
// step if the previous result has still not been taken.
// Reset (rst_n, asynchronous, active low) restores the register defaults,
// clears the window and fade state, and marks the window for recompute.
module night_dimming_scheduler #(
    parameter int FADE_FRACTION_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    ndsch_chan_if.sink    tick,
    ndsch_chan_if.source  result,
    ndsch_chan_if.sink    cfg
);

    localparam int LW = FADE_FRACTION_BITS + 1;
    localparam int PW = LW + 10;
    localparam logic [LW-1:0] FULL = {1'b1, {FADE_FRACTION_BITS{1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_W1,
        S_W2,
        S_W3,
        S_W4,
        S_W5,
        S_W6,
        S_W7,
        S_W8,
        S_FLAG,
        S_INTV,
        S_ELAP,
        S_FADE,
        S_FADE2,
        S_DIVW,
        S_MB,
        S_MB2,
        S_ME2,
        S_OUT
    } seq_state_t;

    // Configuration registers.
    logic        enable_reg;
    logic [16:0] start_off_reg;
    logic [16:0] end_off_reg;
    logic [16:0] fade_sec_reg;
    logic [7:0]  day_bright_reg;
    logic [7:0]  night_bright_reg;
    logic [7:0]  day_eco_reg;
    logic [7:0]  night_eco_reg;

    // Scheduler state.
    seq_state_t  state_reg;
    logic        pending_reg;
    logic        night_reg;
    logic [LW-1:0] fade_reg;
    logic [31:0] last_ms_reg;
    logic [31:0] fade_start_reg;
    logic [31:0] full_start_reg;
    logic [31:0] full_end_reg;
    logic [31:0] fade_end_reg;

    // Per-tick working registers.
    logic [31:0] now_reg;
    logic [31:0] mid_reg;
    logic [31:0] ms_reg;
    logic        tvalid_reg;
    logic [31:0] wmid_reg;
    logic        late_reg;
    logic        ret_blend_reg;
    logic        core_reg;
    logic signed [PW-1:0] prod_reg;
    logic [7:0]  bright_reg;
    logic [7:0]  eco_reg;
    logic        result_valid_reg;
    ndsch_pkg::result_t result_reg;

    logic        cfg_write;
    logic        cfg_hit;
    logic [16:0] so_c;
    logic [16:0] eo_c;
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic        alu_sub;
    logic [31:0] alu_sum;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [LW-1:0] div_level;
    logic signed [8:0]  mul_d;
    logic signed [LW:0] mul_f;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] prod_shift;
    logic [31:0] interval;
    logic        out_free;

    // Configuration port: always ready, registers masked to their widths.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_write)
        begin
            case (cfg.payload.index)
                ndsch_pkg::REG_NIGHT_ENABLE,
                ndsch_pkg::REG_NIGHT_START,
                ndsch_pkg::REG_NIGHT_END,
                ndsch_pkg::REG_FADE_SECONDS,
                ndsch_pkg::REG_DAY_BRIGHTNESS,
                ndsch_pkg::REG_NIGHT_BRIGHTNESS,
                ndsch_pkg::REG_DAY_ECO,
                ndsch_pkg::REG_NIGHT_ECO: cfg_hit = 1'b1;
                default:                  cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            start_off_reg    <= '0;
            end_off_reg      <= '0;
            fade_sec_reg     <= '0;
            day_bright_reg   <= 8'd255;
            night_bright_reg <= 8'd0;
            day_eco_reg      <= 8'd255;
            night_eco_reg    <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg.payload.index)
                ndsch_pkg::REG_NIGHT_ENABLE:     enable_reg       <= cfg.payload.data[0];
                ndsch_pkg::REG_NIGHT_START:      start_off_reg    <= cfg.payload.data[16:0];
                ndsch_pkg::REG_NIGHT_END:        end_off_reg      <= cfg.payload.data[16:0];
                ndsch_pkg::REG_FADE_SECONDS:     fade_sec_reg     <= cfg.payload.data[16:0];
                ndsch_pkg::REG_DAY_BRIGHTNESS:   day_bright_reg   <= cfg.payload.data[7:0];
                ndsch_pkg::REG_NIGHT_BRIGHTNESS: night_bright_reg <= cfg.payload.data[7:0];
                ndsch_pkg::REG_DAY_ECO:          day_eco_reg      <= cfg.payload.data[7:0];
                ndsch_pkg::REG_NIGHT_ECO:        night_eco_reg    <= cfg.payload.data[7:0];
                default:                         ;
            endcase
        end
    end

    // Offsets clamped to one day.
    assign so_c = (start_off_reg > ndsch_pkg::DAY_SECONDS[16:0]) ?
                  ndsch_pkg::DAY_SECONDS[16:0] : start_off_reg;
    assign eo_c = (end_off_reg > ndsch_pkg::DAY_SECONDS[16:0]) ?
                  ndsch_pkg::DAY_SECONDS[16:0] : end_off_reg;

    // Operand selection for the shared adder, one sum per sequencer step.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_W1:
            begin
                alu_a = mid_reg;
                alu_b = {15'd0, eo_c};
            end
            S_W2:
            begin
                alu_a = fade_end_reg;
                alu_b = {15'd0, fade_sec_reg};
            end
            S_W3:
            begin
                alu_a = fade_end_reg;
                alu_b = ndsch_pkg::DAY_SECONDS;
            end
            S_W4:
            begin
                alu_a = wmid_reg;
                alu_b = ndsch_pkg::DAY_SECONDS;
            end
            S_W5:
            begin
                alu_a = wmid_reg;
                alu_b = {15'd0, so_c};
            end
            S_W6:
            begin
                alu_a   = full_start_reg;
                alu_b   = ndsch_pkg::DAY_SECONDS;
                alu_sub = 1'b1;
            end
            S_W7:
            begin
                alu_a   = full_start_reg;
                alu_b   = {15'd0, fade_sec_reg};
                alu_sub = 1'b1;
            end
            S_W8:
            begin
                alu_a   = fade_end_reg;
                alu_b   = {15'd0, fade_sec_reg};
                alu_sub = 1'b1;
            end
            S_ELAP:
            begin
                alu_a   = ms_reg;
                alu_b   = last_ms_reg;
                alu_sub = 1'b1;
            end
            S_FADE:
            begin
                alu_a   = now_reg;
                alu_b   = fade_start_reg;
                alu_sub = 1'b1;
            end
            S_FADE2:
            begin
                alu_a   = fade_end_reg;
                alu_b   = now_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    ndsch_addsub u_addsub (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    // The ramp division starts from the rising or the falling ramp step.
    assign div_start = ((state_reg == S_FADE) && (now_reg < full_start_reg)) ||
                       ((state_reg == S_FADE2) && (now_reg >= full_end_reg) &&
                        (now_reg < fade_end_reg));

    ndsch_ramp_div #(
        .FRAC_BITS (FADE_FRACTION_BITS)
    ) u_ramp_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .elapsed (alu_sum),
        .divisor (fade_sec_reg),
        .busy    (div_busy),
        .done    (div_done),
        .level   (div_level)
    );

    // Shared multiplier for the blend: from + floor((to - from) * f / full).
    always_comb
    begin
        if (state_reg == S_MB)
        begin
            mul_d = $signed({1'b0, night_bright_reg}) - $signed({1'b0, day_bright_reg});
        end
        else
        begin
            mul_d = $signed({1'b0, night_eco_reg}) - $signed({1'b0, day_eco_reg});
        end
        mul_f      = $signed({1'b0, fade_reg});
        mul_p      = PW'(mul_d) * PW'(mul_f);
        prod_shift = prod_reg >>> FADE_FRACTION_BITS;
    end

    assign interval = core_reg ? ndsch_pkg::HOLD_UPDATE_MS : ndsch_pkg::FADE_UPDATE_MS;
    assign out_free = !result_valid_reg || result.ready;

    // Sequencer with the scheduler state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pending_reg      <= 1'b1;
            night_reg        <= 1'b0;
            fade_reg         <= '0;
            last_ms_reg      <= '0;
            fade_start_reg   <= '0;
            full_start_reg   <= '0;
            full_end_reg     <= '0;
            fade_end_reg     <= '0;
            result_valid_reg <= 1'b0;
            ret_blend_reg    <= 1'b0;
        end
        else
        begin
            // A result taken at the load step is replaced there instead.
            if (result_valid_reg && result.ready && (state_reg != S_OUT))
            begin
                result_valid_reg <= 1'b0;
            end
            // A register write marks the window stale; an enabled tick consumes the mark.
            if (cfg_hit)
            begin
                pending_reg <= 1'b1;
            end
            else if ((state_reg == S_CHECK) && enable_reg && tvalid_reg)
            begin
                pending_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (tick.valid)
                    begin
                        now_reg    <= tick.payload.now_seconds;
                        mid_reg    <= tick.payload.day_start_seconds;
                        ms_reg     <= tick.payload.ms_time;
                        tvalid_reg <= tick.payload.time_valid;
                        state_reg  <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (!(enable_reg && tvalid_reg))
                    begin
                        state_reg <= S_MB;
                    end
                    else if (pending_reg)
                    begin
                        ret_blend_reg <= 1'b0;
                        state_reg     <= S_W1;
                    end
                    else
                    begin
                        state_reg <= S_FLAG;
                    end
                end
                // Window: end of fade first, then the full start, then the rest.
                S_W1:
                begin
                    fade_end_reg <= alu_sum;
                    wmid_reg     <= mid_reg;
                    state_reg    <= S_W2;
                end
                S_W2:
                begin
                    fade_end_reg <= alu_sum;
                    state_reg    <= S_W3;
                end
                S_W3:
                begin
                    late_reg <= now_reg > fade_end_reg;
                    if (now_reg > fade_end_reg)
                    begin
                        fade_end_reg <= alu_sum;
                    end
                    state_reg <= S_W4;
                end
                S_W4:
                begin
                    if (late_reg)
                    begin
                        wmid_reg <= alu_sum;
                    end
                    state_reg <= S_W5;
                end
                S_W5:
                begin
                    full_start_reg <= alu_sum;
                    state_reg      <= S_W6;
                end
                S_W6:
                begin
                    // A window that wraps past midnight starts the day before.
                    if (so_c > eo_c)
                    begin
                        full_start_reg <= alu_sum;
                    end
                    state_reg <= S_W7;
                end
                S_W7:
                begin
                    fade_start_reg <= alu_sum;
                    state_reg      <= S_W8;
                end
                S_W8:
                begin
                    full_end_reg <= alu_sum;
                    state_reg    <= ret_blend_reg ? S_MB : S_FLAG;
                end
                S_FLAG:
                begin
                    night_reg <= (now_reg >= fade_start_reg) && (now_reg <= fade_end_reg);
                    if ((now_reg >= fade_start_reg) && (now_reg <= fade_end_reg))
                    begin
                        state_reg <= S_INTV;
                    end
                    else if (now_reg > fade_start_reg)
                    begin
                        ret_blend_reg <= 1'b1;
                        state_reg     <= S_W1;
                    end
                    else
                    begin
                        state_reg <= S_MB;
                    end
                end
                S_INTV:
                begin
                    core_reg  <= (now_reg >= full_start_reg) && (now_reg <= full_end_reg);
                    state_reg <= S_ELAP;
                end
                S_ELAP:
                begin
                    // Throttle: refresh the fade level only once the interval has passed.
                    if (alu_sum > interval)
                    begin
                        last_ms_reg <= ms_reg;
                        state_reg   <= S_FADE;
                    end
                    else
                    begin
                        state_reg <= S_MB;
                    end
                end
                S_FADE:
                begin
                    state_reg <= (now_reg < full_start_reg) ? S_DIVW : S_FADE2;
                end
                S_FADE2:
                begin
                    if (now_reg < full_end_reg)
                    begin
                        fade_reg  <= FULL;
                        state_reg <= S_MB;
                    end
                    else if (now_reg < fade_end_reg)
                    begin
                        state_reg <= S_DIVW;
                    end
                    else
                    begin
                        fade_reg  <= '0;
                        state_reg <= S_MB;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        fade_reg  <= div_level;
                        state_reg <= S_MB;
                    end
                end
                S_MB:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MB2;
                end
                S_MB2:
                begin
                    bright_reg <= day_bright_reg + prod_shift[7:0];
                    prod_reg   <= mul_p;
                    state_reg  <= S_ME2;
                end
                S_ME2:
                begin
                    eco_reg   <= day_eco_reg + prod_shift[7:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // Load the result once the previous one has been taken.
                    if (out_free)
                    begin
                        result_reg.night_active     <= night_reg;
                        result_reg.brightness_level <= night_reg ? bright_reg : 8'd0;
                        result_reg.eco_level        <= night_reg ? eco_reg : 8'd0;
                        result_reg.fade_level       <= night_reg ? 9'(fade_reg) : 9'd0;
                        result_valid_reg            <= 1'b1;
                        state_reg                   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign tick.ready     = (state_reg == S_IDLE);
    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

    // A tick transfer makes the block busy until its result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready |=> !tick.ready)
        else $error("tick accepted while a tick is still in progress");

    // The fade level never exceeds full.
    assert property (@(posedge clk) disable iff (!rst_n)
        fade_reg <= FULL)
        else $error("fade level above full");

    // The ramp divider only runs while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_DIVW)
        else $error("ramp divider busy outside its wait step");

    // Results outside night carry zero levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.payload.night_active |->
        result.payload.brightness_level == 8'd0 && result.payload.eco_level == 8'd0 &&
        result.payload.fade_level == 9'd0)
        else $error("nonzero level outside night");

endmodule
